FILE: sv/otb_pkg.sv
package otb_pkg;

	localparam int MASK_W = 8;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [2:0] timer_index;
		logic [7:0] target_seconds;
	} req_t;

	typedef struct packed {
		logic              expired;
		logic [MASK_W-1:0] pending_mask;
		logic [MASK_W-1:0] running_mask;
	} rsp_t;

endpackage

FILE: sv/otb_tick_unit.sv
module otb_tick_unit import otb_pkg::*; #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic [COUNT_WIDTH-1:0] cnt,
	input  logic [COUNT_WIDTH-1:0] tgt,
	input  logic                   run,
	output logic [COUNT_WIDTH-1:0] cnt_next,
	output logic                   fire
);

	logic [COUNT_WIDTH-1:0] cnt_inc;

	// count wraps, so a zero target fires after a full turn
	assign cnt_inc  = cnt + COUNT_WIDTH'(1);
	assign cnt_next = run ? cnt_inc : cnt;
	assign fire     = run && (cnt_inc == tgt);

endmodule

FILE: sv/eight_channel_oneshot_timer_bank.sv
// Bank of NUM_TIMERS one-shot timers driven by a one-second tick request. A set loads a
// timer's target, clears its count and pending flag and starts it; a tick advances every
// running timer, and a timer that reaches its target raises its pending flag and stops;
// a poll returns and clears one pending flag. Each request yields one response carrying
// the pending and running masks of timers 0..7. A set or poll passes through the execute
// and finish states; a tick reaches the finish state once the timers have passed one
// per cycle through a single shared increment-and-compare unit. req_ready is low
// while a request is being worked on; a finished response waits in an output register
// and does not block the next request.
module eight_channel_oneshot_timer_bank import otb_pkg::*; #(
	parameter int NUM_TIMERS  = 8,
	parameter int COUNT_WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_TICK, S_FINISH} state_t;

	state_t                 state_q;
	req_t                   req_q;
	logic [IDX_W-1:0]       idx_q;
	logic [NUM_TIMERS-1:0]  run_q;
	logic [NUM_TIMERS-1:0]  pend_q;
	logic [COUNT_WIDTH-1:0] elapsed_q [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] target_q  [NUM_TIMERS];
	logic                   expired_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic [IDX_W-1:0]       set_idx;
	logic [IDX_W-1:0]       poll_idx;
	logic                   poll_ok;
	logic [COUNT_WIDTH-1:0] cnt_next;
	logic                   fire;

	// out-of-range set saturates to the last timer, out-of-range poll reads as clear
	always_comb begin
		poll_ok  = int'(req_q.timer_index) < NUM_TIMERS;
		poll_idx = IDX_W'(req_q.timer_index);
		if (int'(req_q.timer_index) >= NUM_TIMERS) begin
			set_idx = IDX_W'(NUM_TIMERS - 1);
		end else begin
			set_idx = IDX_W'(req_q.timer_index);
		end
	end

	otb_tick_unit #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tick (
		.cnt     (elapsed_q[idx_q]),
		.tgt     (target_q[idx_q]),
		.run     (run_q[idx_q]),
		.cnt_next(cnt_next),
		.fire    (fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			idx_q       <= '0;
			run_q       <= '0;
			pend_q      <= '0;
			expired_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				elapsed_q[i] <= '0;
				target_q[i]  <= '0;
			end
		end else begin
			// the finish state reloads the output register itself
			if (rsp_valid_q && rsp_ready && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q     <= req;
						idx_q     <= '0;
						expired_q <= 1'b0;
						state_q   <= (req.opcode == OP_TICK) ? S_TICK : S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (req_q.opcode)
						OP_SET: begin
							elapsed_q[set_idx] <= '0;
							target_q[set_idx]  <= COUNT_WIDTH'(req_q.target_seconds);
							pend_q[set_idx]    <= 1'b0;
							run_q[set_idx]     <= 1'b1;
						end
						OP_POLL: begin
							if (poll_ok && pend_q[poll_idx]) begin
								pend_q[poll_idx] <= 1'b0;
								expired_q        <= 1'b1;
							end
						end
						default: ;
					endcase
					state_q <= S_FINISH;
				end
				S_TICK: begin
					elapsed_q[idx_q] <= cnt_next;
					if (fire) begin
						pend_q[idx_q] <= 1'b1;
						run_q[idx_q]  <= 1'b0;
					end
					if (idx_q == IDX_W'(NUM_TIMERS - 1)) begin
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.expired      <= expired_q;
						rsp_q.pending_mask <= MASK_W'(pend_q);
						rsp_q.running_mask <= MASK_W'(run_q);
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sv/otb_checker.sv
module otb_checker import otb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	logic       req_acc;
	logic       rsp_acc;
	logic [1:0] outst_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			outst_q <= outst_q + 2'd1;
		end else if (!req_acc && rsp_acc) begin
			outst_q <= outst_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("ready still high right after a request");

	a_flags_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pending_mask & rsp.running_mask) == '0)
		else $error("timer reported both pending and running");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outst_q != 2'd0)
		else $error("response without a request");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> outst_q != 2'd2)
		else $error("request taken with two already outstanding");

endmodule

bind eight_channel_oneshot_timer_bank otb_checker u_otb_checker (.*);

FILE: bench/eight_channel_oneshot_timer_bank_test.sv
module eight_channel_oneshot_timer_bank_test;
	import otb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMERS = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 480;
	localparam int MAX_PRINTS = 40;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// timer bank prediction state
	logic [7:0] elapsed_secs [TIMERS];
	logic [7:0] target_secs [TIMERS];
	logic [TIMERS-1:0] run_flags;
	logic [TIMERS-1:0] pend_flags;

	rsp_t expected_responses [$];
	int error_count = 0;

	// sender burst shaping
	int burst_left = 0;
	bit sender_gaps = 1'b0;

	// receiver stall shaping
	rx_mode_t rx_mode = RX_ALWAYS;
	int holdoff_request = 0;
	int holdoff_left = 0;
	int rx_phase = 0;

	eight_channel_oneshot_timer_bank u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t apply_timer_request(req_t r);
		rsp_t o;
		o = '0;
		case (r.opcode)
			OP_TICK: begin
				for (int i = 0; i < TIMERS; i++) begin
					if (run_flags[i]) begin
						elapsed_secs[i] = elapsed_secs[i] + 8'd1;
						if (elapsed_secs[i] == target_secs[i]) begin
							pend_flags[i] = 1'b1;
							run_flags[i] = 1'b0;
						end
					end
				end
			end
			OP_SET: begin
				elapsed_secs[r.timer_index] = 8'd0;
				target_secs[r.timer_index] = r.target_seconds;
				pend_flags[r.timer_index] = 1'b0;
				run_flags[r.timer_index] = 1'b1;
			end
			OP_POLL: begin
				if (pend_flags[r.timer_index]) begin
					pend_flags[r.timer_index] = 1'b0;
					o.expired = 1'b1;
				end
			end
			default: begin
			end
		endcase
		o.pending_mask = pend_flags;
		o.running_mask = run_flags;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic send_request(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_responses.push_back(apply_timer_request(r));
		burst_left--;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [2:0] idx, input logic [7:0] tgt);
		req_t r;
		r.opcode = op;
		r.timer_index = idx;
		r.target_seconds = tgt;
		send_request(r);
	endtask

	function automatic req_t random_request();
		req_t r;
		int sel;
		r.timer_index = 3'($urandom_range(0, 7));
		// mostly short targets so timers actually expire between polls
		if ($urandom_range(0, 3) == 0)
			r.target_seconds = 8'($urandom_range(0, 255));
		else
			r.target_seconds = 8'($urandom_range(1, 6));
		sel = $urandom_range(0, 99);
		if (sel < 50)
			r.opcode = OP_TICK;
		else if (sel < 70)
			r.opcode = OP_SET;
		else if (sel < 95)
			r.opcode = OP_POLL;
		else
			r.opcode = OP_UNUSED;
		return r;
	endfunction

	// receiver ready pattern plus an optional long hold-off
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (holdoff_request > 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  rsp_ready <= 1'b1;
				RX_RANDOM:  rsp_ready <= ($urandom_range(0, 9) < 6);
				RX_PATTERN: rsp_ready <= ((rx_phase % 7) < 4);
				default:    rsp_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_responses.size() == 0) begin
				report_mismatch("unexpected response", 32'(rsp), 32'd0);
			end else begin
				want = expected_responses.pop_front();
				if (rsp.expired !== want.expired)
					report_mismatch("expired", 32'(rsp.expired), 32'(want.expired));
				if (rsp.pending_mask !== want.pending_mask)
					report_mismatch("pending_mask", 32'(rsp.pending_mask),
						32'(want.pending_mask));
				if (rsp.running_mask !== want.running_mask)
					report_mismatch("running_mask", 32'(rsp.running_mask),
						32'(want.running_mask));
			end
		end
	end

	task automatic test_basic_ops();
		send_op(OP_POLL, 3'd0, 8'd0);
		send_op(OP_UNUSED, 3'd7, 8'hFF);
		send_op(OP_TICK, 3'd5, 8'h5A);
		send_op(OP_SET, 3'd0, 8'd1);
		send_op(OP_TICK, 3'd0, 8'd0);
		send_op(OP_POLL, 3'd0, 8'd0);
		send_op(OP_POLL, 3'd0, 8'd0);
		send_op(OP_SET, 3'd7, 8'hFF);
		send_op(OP_SET, 3'd3, 8'd2);
		send_op(OP_TICK, 3'd0, 8'd0);
		// restart a running timer from zero
		send_op(OP_SET, 3'd3, 8'd2);
		send_op(OP_TICK, 3'd0, 8'd0);
		send_op(OP_TICK, 3'd0, 8'd0);
		send_op(OP_POLL, 3'd7, 8'd0);
		send_op(OP_SET, 3'd5, 8'hAA);
		send_op(OP_SET, 3'd6, 8'h55);
		send_op(OP_UNUSED, 3'd3, 8'h00);
		send_op(OP_POLL, 3'd3, 8'hFF);
		// re-setting an expired timer clears its pending flag
		send_op(OP_SET, 3'd0, 8'd1);
		send_op(OP_TICK, 3'd0, 8'd0);
		send_op(OP_SET, 3'd0, 8'd3);
		send_op(OP_POLL, 3'd0, 8'd0);
	endtask

	task automatic test_zero_target_wrap();
		send_op(OP_SET, 3'd2, 8'd0);
		send_op(OP_SET, 3'd4, 8'd255);
		send_op(OP_SET, 3'd1, 8'd128);
		for (int i = 0; i < 256; i++)
			send_op(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
		send_op(OP_POLL, 3'd2, 8'd0);
		send_op(OP_POLL, 3'd4, 8'd0);
		send_op(OP_POLL, 3'd1, 8'd0);
	endtask

	task automatic test_output_holdoff();
		sender_gaps = 1'b0;
		holdoff_request = 200;
		for (int i = 0; i < 40; i++)
			send_request(random_request());
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				if (i == 0) begin
					sender_gaps = 1'b0;
					rx_mode = RX_ALWAYS;
				end else begin
					sender_gaps = ($urandom_range(0, 3) != 0);
					rx_mode = rx_mode_t'($urandom_range(0, 2));
				end
			end
			send_request(random_request());
		end
	endtask

	initial begin
		for (int i = 0; i < TIMERS; i++) begin
			elapsed_secs[i] = 8'd0;
			target_secs[i] = 8'd0;
		end
		run_flags = '0;
		pend_flags = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_gaps = 1'b1;
		rx_mode = RX_RANDOM;
		test_basic_ops();
		rx_mode = RX_PATTERN;
		test_zero_target_wrap();
		test_output_holdoff();
		test_random_mix();

		req_valid <= 1'b0;
		rx_mode = RX_ALWAYS;
		while (expected_responses.size() != 0)
			@(posedge clk);
		// every accepted request has been answered here, so no tick is still walking the timers
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
